[rtl/lts_pkg.sv]
// shared types and constants for the lottery ticket scheduler
package lts_pkg;

  localparam int unsigned RNG_BITS = 31;
  localparam logic [RNG_BITS-1:0] LCG_MUL = 31'd1103515245;
  localparam logic [RNG_BITS-1:0] LCG_ADD = 31'd12345;

  typedef enum logic [0:0] {
    CMD_WRITE = 1'b0,
    CMD_SCHED = 1'b1
  } cmd_t;

  typedef enum logic [2:0] {
    ST_FREE     = 3'd0,
    ST_DYING    = 3'd1,
    ST_RUNNABLE = 3'd2,
    ST_RUNNING  = 3'd3,
    ST_BLOCKED  = 3'd4
  } status_code_t;

  typedef enum logic [1:0] {
    OUT_WRITE = 2'd0,
    OUT_RUN   = 2'd1,
    OUT_HALT  = 2'd2,
    OUT_DEAD  = 2'd3
  } outcome_t;

  // controller to datapath
  typedef struct packed {
    logic do_write;   // table write of the captured item
    logic clr_scan;   // clear walk index and accumulators
    logic sum_step;   // accumulate runnable tickets for one entry
    logic rng_step;   // advance the generator
    logic mod_start;  // start a modulo reduction
    logic mod_sel;    // 0 modulus sum+1, 1 modulus candidate count
    logic cand_step;  // candidate walk for one entry
    logic pick_step;  // walk to the picked candidate
    logic commit_cur; // rerun current entry
    logic commit_pick;// run picked entry
    logic halt;       // apply halt result
  } lts_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic scan_last;  // walk index at last entry
    logic sum_zero;
    logic cur_ok;     // current entry valid and running
    logic cur_tix;    // current entry has tickets
    logic mod_done;
    logic have_cand;
    logic pick_hit;   // picked candidate found at this index
  } lts_stat_t;

endpackage

[rtl/lts_if.sv]
// valid/ready channel interfaces
interface lts_in_if;
  logic        valid;
  logic        ready;
  logic [0:0]  command;
  logic [3:0]  entry_index;
  logic [2:0]  entry_state;
  logic [15:0] ticket_count;
  modport source (output valid, command, entry_index, entry_state, ticket_count,
                  input ready);
  modport sink (input valid, command, entry_index, entry_state, ticket_count,
                output ready);
endinterface

interface lts_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] outcome;
  logic [3:0] chosen;
  modport source (output valid, outcome, chosen, input ready);
  modport sink (input valid, outcome, chosen, output ready);
endinterface

[rtl/lts_ctrl.sv]
// scheduler controller state machine
module lts_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              in_sched,
  output logic              in_ready,
  input  logic              out_free,
  output logic              out_load,
  output lts_pkg::lts_cmd_t cmd,
  input  lts_pkg::lts_stat_t stat
);
  import lts_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE = 8'b00000001,
    S_SUM  = 8'b00000010,
    S_DEC  = 8'b00000100,
    S_MOD1 = 8'b00001000,
    S_CAND = 8'b00010000,
    S_MOD2 = 8'b00100000,
    S_PICK = 8'b01000000,
    S_DONE = 8'b10000000
  } state_t;

  state_t state, state_next;

  assign in_ready = (state == S_IDLE) && out_free;

  // next state and commands
  always_comb begin
    state_next = state;
    cmd = '0;
    out_load = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (in_valid && out_free) begin
          cmd.clr_scan = 1'b1;
          if (in_sched) begin
            state_next = S_SUM;
          end else begin
            cmd.do_write = 1'b1;
            out_load = 1'b1;
          end
        end
      end
      S_SUM: begin
        cmd.sum_step = 1'b1;
        if (stat.scan_last) state_next = S_DEC;
      end
      S_DEC: begin
        cmd.clr_scan = 1'b1;
        if (stat.sum_zero && stat.cur_ok) begin
          if (stat.cur_tix) cmd.commit_cur = 1'b1;
          else cmd.halt = 1'b1;
          state_next = S_DONE;
        end else begin
          cmd.rng_step = 1'b1;
          cmd.mod_start = 1'b1;
          state_next = S_MOD1;
        end
      end
      S_MOD1: begin
        if (stat.mod_done) state_next = S_CAND;
      end
      S_CAND: begin
        cmd.cand_step = 1'b1;
        if (stat.scan_last) state_next = S_MOD2;
      end
      S_MOD2: begin
        if (!stat.have_cand) begin
          cmd.halt = 1'b1;
          state_next = S_DONE;
        end else begin
          cmd.rng_step = 1'b1;
          cmd.mod_start = 1'b1;
          cmd.mod_sel = 1'b1;
          cmd.clr_scan = 1'b1;
          state_next = S_PICK;
        end
      end
      S_PICK: begin
        if (stat.mod_done) begin
          cmd.pick_step = 1'b1;
          if (stat.pick_hit) begin
            cmd.commit_pick = 1'b1;
            state_next = S_DONE;
          end
        end
      end
      S_DONE: begin
        out_load = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> state == S_IDLE) else $error("ready outside idle");
  a_one_commit: assert property (@(posedge clk) disable iff (rst)
    !(cmd.commit_pick && cmd.halt)) else $error("run and halt together");
  a_done_load: assert property (@(posedge clk) disable iff (rst)
    state == S_DONE |-> out_load) else $error("result not loaded");
endmodule

[rtl/lts_dp.sv]
// scheduler datapath: tables, generator, modulo unit, walk
module lts_dp #(
  parameter int unsigned ENTRIES     = 16,
  parameter int unsigned TICKET_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               seed_we,
  input  logic [30:0]        seed_wdata,
  input  logic [3:0]         wr_index,
  input  logic [2:0]         wr_state,
  input  logic [15:0]        wr_tickets,
  input  lts_pkg::lts_cmd_t  cmd,
  output lts_pkg::lts_stat_t stat,
  output logic [1:0]         res_outcome,
  output logic [3:0]         res_chosen
);
  import lts_pkg::*;

  localparam int unsigned IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned SW = TICKET_BITS + IW + 1;
  localparam int unsigned CW = IW + 1;
  localparam int unsigned MW = (SW > RNG_BITS) ? SW : RNG_BITS;

  logic [2:0]             st_tab [ENTRIES];
  logic [TICKET_BITS-1:0] tk_tab [ENTRIES];
  logic [RNG_BITS-1:0]    seed, rng;
  logic                   cur_valid;
  logic [IW-1:0]          cur_slot;
  logic [IW-1:0]          idx;
  logic [SW-1:0]          sum, run;
  logic [SW-1:0]          thr;
  logic [CW-1:0]          ncand, pick_cnt;
  logic [MW-1:0]          rem, div;
  logic [5:0]             mbit;
  logic                   mbusy;
  logic [RNG_BITS-1:0]    rng_src, rng_nx;
  logic [2*RNG_BITS-1:0]  prod;
  logic [SW-1:0]          run_nx;
  logic                   alive;
  logic [TICKET_BITS-1:0] wr_tk;

  assign wr_tk = TICKET_BITS'(wr_tickets);

  // generator step, zero state reloads seed
  assign rng_src = (rng == '0) ? seed : rng;
  assign prod    = rng_src * LCG_MUL;
  assign rng_nx  = prod[RNG_BITS-1:0] + LCG_ADD;

  assign run_nx = run + SW'(tk_tab[idx]);

  // any slot alive for halt
  always_comb begin
    alive = 1'b0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (st_tab[i] == ST_RUNNABLE || st_tab[i] == ST_RUNNING || st_tab[i] == ST_DYING)
        alive = 1'b1;
    end
  end

  assign stat.scan_last = (idx == IW'(ENTRIES - 1));
  assign stat.sum_zero  = (sum == '0);
  assign stat.cur_ok    = cur_valid && (st_tab[cur_slot] == ST_RUNNING);
  assign stat.cur_tix   = (tk_tab[cur_slot] != '0);
  assign stat.mod_done  = !mbusy;
  assign stat.have_cand = (ncand != '0);
  assign stat.pick_hit  = (st_tab[idx] == ST_RUNNABLE) && (run_nx > thr)
                          && (pick_cnt == CW'(rem));

  // shift-subtract modulo: rem = rng mod div, one bit a cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      mbusy <= 1'b0;
    end else if (cmd.mod_start) begin
      mbusy <= 1'b1;
      mbit  <= 6'(RNG_BITS - 1);
      rem   <= '0;
      div   <= cmd.mod_sel ? MW'(ncand) : MW'(sum + SW'(1));
    end else if (mbusy) begin
      if ({rem, rng[mbit[4:0]]} >= {1'b0, div})
        rem <= MW'({rem, rng[mbit[4:0]]} - {1'b0, div});
      else rem <= {rem[MW-2:0], rng[mbit[4:0]]};
      if (mbit == '0) mbusy <= 1'b0;
      mbit <= mbit - 6'd1;
    end
  end

  // walk, generator and table updates
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < ENTRIES; i++) begin
        st_tab[i] <= ST_FREE;
        tk_tab[i] <= '0;
      end
      seed <= 31'd1;
      rng <= 31'd1;
      cur_valid <= 1'b0;
      cur_slot <= '0;
      idx <= '0;
      sum <= '0;
      run <= '0;
      thr <= '0;
      ncand <= '0;
      pick_cnt <= '0;
    end else begin
      if (seed_we) begin
        seed <= seed_wdata;
        rng <= seed_wdata;
      end else if (cmd.rng_step) begin
        rng <= rng_nx;
      end
      if (cmd.do_write && 32'(wr_index) < ENTRIES) begin
        st_tab[IW'(wr_index)] <= wr_state;
        tk_tab[IW'(wr_index)] <= wr_tk;
      end
      if (cmd.clr_scan) begin
        idx <= '0;
        run <= '0;
        pick_cnt <= '0;
        sum <= '0;
        if (cmd.do_write || !cmd.mod_sel) ncand <= cmd.rng_step ? '0 : ncand;
      end
      if (cmd.sum_step) begin
        if (st_tab[idx] == ST_RUNNABLE) sum <= sum + SW'(tk_tab[idx]);
        idx <= idx + IW'(1);
      end
      // first draw kept for the pick walk, rem is reused by the second draw
      if (cmd.cand_step) begin
        run <= run_nx;
        thr <= SW'(rem);
        if (st_tab[idx] == ST_RUNNABLE && run_nx > SW'(rem)) ncand <= ncand + CW'(1);
        idx <= idx + IW'(1);
      end
      if (cmd.pick_step) begin
        run <= run_nx;
        if (st_tab[idx] == ST_RUNNABLE && run_nx > thr) pick_cnt <= pick_cnt + CW'(1);
        idx <= idx + IW'(1);
      end
      if (cmd.commit_cur) tk_tab[cur_slot] <= tk_tab[cur_slot] - TICKET_BITS'(1);
      if (cmd.commit_pick) begin
        if (tk_tab[idx] != '0) tk_tab[idx] <= tk_tab[idx] - TICKET_BITS'(1);
        if (cur_valid && cur_slot != idx && st_tab[cur_slot] == ST_RUNNING)
          st_tab[cur_slot] <= ST_RUNNABLE;
        st_tab[idx] <= ST_RUNNING;
        cur_valid <= 1'b1;
        cur_slot <= idx;
      end
      if (cmd.halt && alive) cur_valid <= 1'b0;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_outcome <= OUT_WRITE;
      res_chosen <= '0;
    end else if (cmd.do_write) begin
      res_outcome <= OUT_WRITE;
      res_chosen <= '0;
    end else if (cmd.commit_cur) begin
      res_outcome <= OUT_RUN;
      res_chosen <= 4'(cur_slot);
    end else if (cmd.commit_pick) begin
      res_outcome <= OUT_RUN;
      res_chosen <= 4'(idx);
    end else if (cmd.halt) begin
      res_outcome <= alive ? OUT_HALT : OUT_DEAD;
      res_chosen <= '0;
    end
  end

  a_pick_runnable: assert property (@(posedge clk) disable iff (rst)
    cmd.commit_pick |-> st_tab[idx] == ST_RUNNABLE) else $error("pick not runnable");
  a_cur_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.commit_pick |=> cur_valid) else $error("current not set");
  a_mod_range: assert property (@(posedge clk) disable iff (rst)
    $fell(mbusy) |-> rem < div) else $error("remainder out of range");
endmodule

[rtl/lottery_ticket_scheduler.sv]
// top level of the lottery ticket scheduler
// Usage:
//   in channel carries commands: a write sets one table entry, a schedule
//   command runs one lottery decision. out channel carries one result per
//   command: outcome and chosen entry.
//   seed_we/seed_wdata load the generator seed and its state; write only
//   while no command is in flight.
// Operation:
//   a schedule walks all entries to sum runnable tickets, reduces the draw by
//   sum+1 in a bit-serial modulo unit, walks again for candidates, reduces
//   the second draw by the candidate count and walks to the winner, one
//   command at a time. A zero sum with a running current entry skips the
//   draws and reruns or halts it; no candidate halts.
// Reset:
//   rst clears the table, seeds the generator with 1 and drops the current
//   entry. The result register holds while the receiver stalls, and a new
//   command is taken once the result slot is free.
module lottery_ticket_scheduler #(
  parameter int unsigned ENTRIES     = 16,
  parameter int unsigned TICKET_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        seed_we,
  input  logic [30:0] seed_wdata,
  lts_in_if.sink      in_ch,
  lts_out_if.source   out_ch
);
  import lts_pkg::*;

  lts_cmd_t   cmd;
  lts_stat_t  stat;
  logic       out_load, out_valid;
  logic [1:0] res_outcome;
  logic [3:0] res_chosen;

  lts_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .in_valid(in_ch.valid), .in_sched(in_ch.command == CMD_SCHED),
    .in_ready(in_ch.ready), .out_free(!out_valid),
    .out_load(out_load), .cmd(cmd), .stat(stat)
  );

  lts_dp #(.ENTRIES(ENTRIES), .TICKET_BITS(TICKET_BITS)) u_dp (
    .clk(clk), .rst(rst), .seed_we(seed_we), .seed_wdata(seed_wdata),
    .wr_index(in_ch.entry_index), .wr_state(in_ch.entry_state),
    .wr_tickets(in_ch.ticket_count), .cmd(cmd), .stat(stat),
    .res_outcome(res_outcome), .res_chosen(res_chosen)
  );

  // result valid flag
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (out_load) out_valid <= 1'b1;
    else if (out_ch.ready) out_valid <= 1'b0;
  end

  assign out_ch.valid   = out_valid;
  assign out_ch.outcome = res_outcome;
  assign out_ch.chosen  = res_chosen;

  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    out_load |-> !out_valid) else $error("result overwritten");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ch.ready |=> out_valid) else $error("result dropped");
  a_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ch.ready) else $error("accept while result pending");
endmodule

[tb/lottery_ticket_scheduler_test.sv]
// self-checking regression bench for the lottery ticket scheduler
`timescale 1ns / 100ps

module lottery_ticket_scheduler_test;
  import lts_pkg::*;

  localparam int NSLOT = 16;
  localparam int CYCLE_LIMIT = 2000000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic seed_we = 1'b0;
  logic [30:0] seed_wdata = 31'd1;

  lts_in_if in_ch ();
  lts_out_if out_ch ();

  lottery_ticket_scheduler dut (
    .clk(clk), .rst(rst), .seed_we(seed_we), .seed_wdata(seed_wdata),
    .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  always #5 clk = ~clk;

  // golden scheduler state
  logic [2:0]  slot_status [NSLOT];
  logic [15:0] slot_tickets [NSLOT];
  logic [30:0] seed_reg;
  logic [30:0] lcg;
  bit          cur_valid;
  logic [3:0]  cur_slot;

  typedef struct packed {
    outcome_t   outcome;
    logic [3:0] chosen;
  } sched_result_t;

  sched_result_t pending_results[$];
  int mismatches = 0;
  int results_seen = 0;
  int runs_seen = 0;
  int halts_seen = 0;
  int deads_seen = 0;
  int items_sent = 0;
  bit hold_sink = 1'b0;
  bit timed_out = 1'b0;
  longint cycles = 0;

  // generator step and draw
  function automatic logic [31:0] lcg_draw(input logic [31:0] n);
    logic [62:0] prod;
    if (lcg == 31'd0) lcg = seed_reg;
    prod = 63'(LCG_MUL) * 63'(lcg) + 63'(LCG_ADD);
    lcg = prod[30:0];
    return (n == 0) ? 32'd0 : 32'(lcg) % n;
  endfunction

  function automatic outcome_t halt_result();
    for (int i = 0; i < NSLOT; i++)
      if (slot_status[i] == ST_RUNNABLE || slot_status[i] == ST_RUNNING ||
          slot_status[i] == ST_DYING) begin
        cur_valid = 1'b0;
        return OUT_HALT;
      end
    return OUT_DEAD;
  endfunction

  function automatic sched_result_t predict_decision(input logic [0:0] cmd,
      input logic [3:0] idx, input logic [2:0] st, input logic [15:0] tix);
    sched_result_t r;
    logic [31:0] total, acc, w, ncand;
    logic [3:0] cands [NSLOT];
    logic [3:0] k;
    r.outcome = OUT_WRITE;
    r.chosen = 4'd0;
    total = 0;
    acc = 0;
    ncand = 0;
    if (cmd == CMD_WRITE) begin
      slot_status[idx] = st;
      slot_tickets[idx] = tix;
      return r;
    end
    for (int i = 0; i < NSLOT; i++)
      if (slot_status[i] == ST_RUNNABLE) total += slot_tickets[i];
    if (total == 0 && cur_valid && slot_status[cur_slot] == ST_RUNNING) begin
      // no runnable tickets: keep the current task while it has tickets
      if (slot_tickets[cur_slot] != 0) begin
        slot_tickets[cur_slot]--;
        r.outcome = OUT_RUN;
        r.chosen = cur_slot;
      end else r.outcome = halt_result();
      return r;
    end
    w = lcg_draw(total + 1);
    for (int i = 0; i < NSLOT; i++) begin
      acc += slot_tickets[i];
      if (slot_status[i] == ST_RUNNABLE && acc > w) begin
        cands[ncand] = 4'(i);
        ncand++;
      end
    end
    if (ncand == 0) begin
      r.outcome = halt_result();
      return r;
    end
    k = cands[lcg_draw(ncand) % ncand];
    if (slot_tickets[k] != 0) slot_tickets[k]--;
    if (cur_valid && cur_slot != k && slot_status[cur_slot] == ST_RUNNING)
      slot_status[cur_slot] = ST_RUNNABLE;
    slot_status[k] = ST_RUNNING;
    cur_valid = 1'b1;
    cur_slot = k;
    r.outcome = OUT_RUN;
    r.chosen = k;
    return r;
  endfunction

  // short gaps mostly, now and then a long one
  function automatic int gap_len();
    int p;
    p = $urandom_range(99);
    if (p < 50) return 0;
    if (p < 92) return $urandom_range(3, 1);
    return $urandom_range(60, 10);
  endfunction

  task automatic send_item(input logic [0:0] cmd, input logic [3:0] idx,
      input logic [2:0] st, input logic [15:0] tix);
    int g;
    g = gap_len();
    if (g > 0) in_ch.valid <= 1'b0;
    repeat (g) @(posedge clk);
    in_ch.valid <= 1'b1;
    in_ch.command <= cmd;
    in_ch.entry_index <= idx;
    in_ch.entry_state <= st;
    in_ch.ticket_count <= tix;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    pending_results.push_back(predict_decision(cmd, idx, st, tix));
    items_sent++;
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (120) @(posedge clk);
  endtask

  task automatic load_seed(input logic [30:0] value);
    wait_drained();
    seed_we <= 1'b1;
    seed_wdata <= value;
    @(posedge clk);
    seed_we <= 1'b0;
    seed_reg = value;
    lcg = value;
  endtask

  // checker of result transfers
  always @(posedge clk) begin
    sched_result_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %0d/%0d",
                                       out_ch.outcome, out_ch.chosen);
      end else begin
        want = pending_results.pop_front();
        case (want.outcome)
          OUT_RUN: runs_seen++;
          OUT_HALT: halts_seen++;
          OUT_DEAD: deads_seen++;
          default: ;
        endcase
        if (out_ch.outcome !== want.outcome || out_ch.chosen !== want.chosen) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected outcome %0d chosen %0d, got %0d %0d",
                     want.outcome, want.chosen, out_ch.outcome, out_ch.chosen);
        end
      end
    end
  end

  // receiver stalls, with an optional long hold-off
  always @(posedge clk) begin
    if (rst || hold_sink) out_ch.ready <= 1'b0;
    else out_ch.ready <= ($urandom_range(99) < 70) ||
                         ($urandom_range(99) < 20 && cycles[9]);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // directed corners: extremes, empty table, rerun and halt
  task automatic test_directed();
    send_item(CMD_SCHED, 4'd0, 3'd0, 16'd0);
    send_item(CMD_WRITE, 4'd15, ST_RUNNABLE, 16'hFFFF);
    send_item(CMD_WRITE, 4'd0, ST_RUNNABLE, 16'd0);
    send_item(CMD_SCHED, 4'd0, 3'd0, 16'd0);
    send_item(CMD_SCHED, 4'd0, 3'd0, 16'd0);
    send_item(CMD_WRITE, 4'd15, ST_BLOCKED, 16'd2);
    send_item(CMD_WRITE, 4'd3, 3'd7, 16'd9);
    send_item(CMD_WRITE, 4'd5, 3'd5, 16'd1);
    send_item(CMD_WRITE, 4'd6, 3'd6, 16'd1);
    send_item(CMD_WRITE, 4'd7, ST_DYING, 16'd4);
    send_item(CMD_WRITE, 4'd0, ST_RUNNING, 16'd1);
    send_item(CMD_SCHED, 4'd0, 3'd0, 16'd0);
    send_item(CMD_SCHED, 4'd0, 3'd0, 16'd0);
    send_item(CMD_SCHED, 4'd0, 3'd0, 16'd0);
    for (int i = 0; i < NSLOT; i++) send_item(CMD_WRITE, 4'(i), ST_FREE, 16'd0);
    send_item(CMD_SCHED, 4'hF, 3'h7, 16'hFFFF);
  endtask

  // random table fills followed by bursts of decisions
  task automatic test_random(input int n_items);
    int sent;
    sent = 0;
    while (sent < n_items) begin
      int nw;
      int ns;
      nw = $urandom_range(6, 1);
      ns = $urandom_range(8, 1);
      for (int i = 0; i < nw; i++) begin
        logic [2:0] st;
        logic [15:0] tix;
        st = ($urandom_range(9) < 6) ? ST_RUNNABLE : 3'($urandom_range(7));
        tix = ($urandom_range(9) < 7) ? 16'($urandom_range(8)) : 16'($urandom);
        send_item(CMD_WRITE, 4'($urandom_range(15)), st, tix);
      end
      for (int i = 0; i < ns; i++)
        send_item(CMD_SCHED, 4'($urandom), 3'($urandom), 16'($urandom));
      sent += nw + ns;
    end
  endtask

  // long receiver hold-off while commands keep coming
  task automatic test_backpressure();
    fork
      begin
        hold_sink = 1'b1;
        repeat (400) @(posedge clk);
        hold_sink = 1'b0;
      end
      test_random(30);
    join
    wait_drained();
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.command = CMD_WRITE;
    in_ch.entry_index = '0;
    in_ch.entry_state = '0;
    in_ch.ticket_count = '0;
    for (int i = 0; i < NSLOT; i++) begin
      slot_status[i] = ST_FREE;
      slot_tickets[i] = '0;
    end
    seed_reg = 31'd1;
    lcg = 31'd1;
    cur_valid = 1'b0;
    cur_slot = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    load_seed(31'h7FFFFFFF);
    test_random(500);
    load_seed(31'd1);
    test_random(400);
    test_backpressure();
    load_seed(31'($urandom_range(32'h7FFFFFFE, 2)));
    test_random(640);
    wait_drained();

    $display("run covered %0d commands, %0d results: %0d runs, %0d halts, %0d none alive",
             items_sent, results_seen, runs_seen, halts_seen, deads_seen);
    $display("seeds at both extremes and a random one, with long output stalls");
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/lts_pkg.sv
rtl/lts_if.sv
rtl/lts_ctrl.sv
rtl/lts_dp.sv
rtl/lottery_ticket_scheduler.sv
tb/lottery_ticket_scheduler_test.sv
